/* rtl/lgrs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Life row stream package
// Shared types, constants and the B3/S23 cell rule for the row stream core.
// ----------------------------------------------------------------------------
package lgrs_pkg;

  localparam int unsigned LGRS_ROW_W       = 64;
  localparam int unsigned LGRS_ROW_CELLS   = 64;
  localparam int unsigned LGRS_WIDTH_W     = 7;
  localparam logic [LGRS_WIDTH_W-1:0] LGRS_WIDTH_RESET = 7'd64;
  localparam int unsigned LGRS_QUEUE_DEPTH = 4;

  localparam logic [3:0] LGRS_BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] LGRS_SURVIVE_COUNT = 4'd2;

  typedef struct packed {
    logic [LGRS_ROW_W-1:0] row_cells;
    logic                  last_row;
  } lgrs_in_t;

  typedef struct packed {
    logic [LGRS_ROW_W-1:0] next_cells;
    logic                  board_end;
    logic                  run_last;
  } lgrs_out_t;

  typedef struct packed {
    logic above;
    logic middle;
    logic row;
  } lgrs_col_t;

  function automatic logic life_next(input logic self, input logic [7:0] nb);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'b000, nb[i]};
    end
    return (n == LGRS_BIRTH_COUNT) || (self && (n == LGRS_SURVIVE_COUNT));
  endfunction

endpackage
`default_nettype wire

/* rtl/lgrs_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Life row stream cell
// Holds one column of the two stored rows and computes that column's next
// state for both possible results of the incoming row.
// ----------------------------------------------------------------------------
module lgrs_cell
  import lgrs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      shift,
  input  wire logic      clear,
  input  wire logic      live,
  input  wire logic      row_bit,
  input  wire lgrs_col_t left,
  input  wire lgrs_col_t right,
  output lgrs_col_t      own,
  output logic           next_a,
  output logic           next_b
);

  logic above_r, above_nxt;
  logic middle_r, middle_nxt;

  assign own.above  = above_r & live;
  assign own.middle = middle_r & live;
  assign own.row    = row_bit & live;

  assign next_a = live & life_next(own.middle,
                                   {left.above, own.above, right.above,
                                    left.middle, right.middle,
                                    left.row, own.row, right.row});
  assign next_b = live & life_next(own.row,
                                   {left.middle, own.middle, right.middle,
                                    left.row, right.row, 3'b000});

  always_comb begin
    above_nxt  = above_r;
    middle_nxt = middle_r;
    if (shift) begin
      if (clear) begin
        above_nxt  = 1'b0;
        middle_nxt = 1'b0;
      end else begin
        above_nxt  = middle_r;
        middle_nxt = row_bit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      above_r  <= 1'b0;
      middle_r <= 1'b0;
    end else begin
      above_r  <= above_nxt;
      middle_r <= middle_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/lgrs_out_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Life row stream result queue
// Small register queue that takes up to two results per cycle and hands out
// one per cycle on the result channel while the consumer is ready.
// ----------------------------------------------------------------------------
module lgrs_out_queue
  import lgrs_pkg::*;
#(
  localparam int unsigned DEPTH = LGRS_QUEUE_DEPTH,
  localparam int unsigned AW    = $clog2(DEPTH),
  localparam int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic [1:0] push_cnt,
  input  wire lgrs_out_t push_data0,
  input  wire lgrs_out_t push_data1,
  input  wire logic      pop,
  output logic           head_valid,
  output lgrs_out_t      head_data,
  output logic [CW-1:0]  count
);

  lgrs_out_t       ent_r [DEPTH];
  logic [AW-1:0]   head_r, head_nxt;
  logic [AW-1:0]   tail_r, tail_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [AW-1:0]   tail_plus;

  assign tail_plus  = tail_r + AW'(1);
  assign head_valid = (count_r != '0);
  assign head_data  = ent_r[head_r];
  assign count      = count_r;

  always_comb begin
    head_nxt  = pop ? head_r + AW'(1) : head_r;
    tail_nxt  = tail_r + AW'(push_cnt);
    count_nxt = count_r + CW'(push_cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      ent_r[tail_r] <= push_data0;
    end
    if (push_cnt == 2'd2) begin
      ent_r[tail_plus] <= push_data1;
    end
  end

endmodule
`default_nettype wire

/* rtl/life_generation_row_stream_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Life generation row stream core
// Computes one B3/S23 generation of a board streamed one row per beat, using
// a row of column cells that hold the two previous rows.
// ----------------------------------------------------------------------------
// Results: each result is written into the result queue when its input beat is taken.
// Throughput: one row per cycle while the result queue has room; a bottom row with rows
// held yields two results, which leave one at a time through a four-entry result queue.
// Reset: clears the held rows and the queue, and sets the width to 64.
// ----------------------------------------------------------------------------
module life_generation_row_stream_core
  import lgrs_pkg::*;
#(
  parameter int unsigned ROW_CELLS = LGRS_ROW_CELLS
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire lgrs_in_t                in_data,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output lgrs_out_t                    out_data,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [LGRS_WIDTH_W-1:0] cfg_data
);

  localparam int unsigned CW = $clog2(LGRS_QUEUE_DEPTH + 1);

  logic [LGRS_WIDTH_W-1:0] width_r, width_nxt;
  logic                    held_r, held_nxt;
  logic                    accept;
  logic                    pop;
  logic [CW-1:0]           q_count;
  lgrs_col_t               own_col [ROW_CELLS];
  logic [ROW_CELLS-1:0]    next_a;
  logic [ROW_CELLS-1:0]    next_b;
  lgrs_out_t               res_a, res_b, push0;
  logic [1:0]              push_cnt;

  assign cfg_ready = 1'b1;
  assign in_ready  = (q_count <= CW'(LGRS_QUEUE_DEPTH - 2));
  assign accept    = in_valid & in_ready;
  assign pop       = out_valid & out_ready;

  for (genvar k = 0; k < ROW_CELLS; k++) begin : g_cell
    lgrs_col_t left, right;
    logic      live;

    assign live = (width_r > LGRS_WIDTH_W'(k));
    if (k == 0) begin : g_lo
      assign left = '0;
    end else begin : g_lo_n
      assign left = own_col[k-1];
    end
    if (k == ROW_CELLS - 1) begin : g_hi
      assign right = '0;
    end else begin : g_hi_n
      assign right = own_col[k+1];
    end

    lgrs_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift   (accept),
      .clear   (in_data.last_row),
      .live    (live),
      .row_bit (in_data.row_cells[k]),
      .left    (left),
      .right   (right),
      .own     (own_col[k]),
      .next_a  (next_a[k]),
      .next_b  (next_b[k])
    );
  end

  always_comb begin
    res_a.next_cells = LGRS_ROW_W'(next_a);
    res_a.board_end  = 1'b0;
    res_a.run_last   = ~in_data.last_row;
    res_b.next_cells = LGRS_ROW_W'(next_b);
    res_b.board_end  = 1'b1;
    res_b.run_last   = 1'b1;
    push0            = held_r ? res_a : res_b;
    push_cnt         = accept ? ({1'b0, held_r} + {1'b0, in_data.last_row}) : 2'd0;
  end

  always_comb begin
    width_nxt = cfg_valid ? cfg_data : width_r;
    held_nxt  = accept ? ~in_data.last_row : held_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= LGRS_WIDTH_RESET;
      held_r  <= 1'b0;
    end else begin
      width_r <= width_nxt;
      held_r  <= held_nxt;
    end
  end

  lgrs_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt   (push_cnt),
    .push_data0 (push0),
    .push_data1 (res_b),
    .pop        (pop),
    .head_valid (out_valid),
    .head_data  (out_data),
    .count      (q_count)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CW'(LGRS_QUEUE_DEPTH))
    else $error("result queue overfilled");

  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.last_row |=> !held_r)
    else $error("held rows not cleared after bottom row");

  a_hold_on_row: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_data.last_row |=> held_r)
    else $error("row not held after inner row");

endmodule
`default_nettype wire
